### sv/color_ramp_sampler_unit_macros.svh
// Assertion macros for the color ramp sampler checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef COLOR_RAMP_SAMPLER_UNIT_MACROS_SVH
`define COLOR_RAMP_SAMPLER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("color ramp sampler check failed");

// Antecedent implies consequent in the next cycle.
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("color ramp sampler check failed");

`endif

### sv/crs_pkg.sv
// Package of the color ramp sampler: widths, codes and the search token type.
// No dependencies.
`default_nettype none
package crs_pkg;
	localparam int POS_W         = 17;
	localparam int COL_W         = 32;
	localparam int IDX_W         = 4;
	localparam int SAMPLE_W      = 18;
	localparam int CNT_W         = 5;
	localparam int MAX_STOPS_DEF = 16;
	localparam logic [POS_W-1:0] ONE_POS = 17'h10000;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Token that walks down the row of stop cells for one sample.
	typedef struct packed {
		logic [POS_W-1:0] t;
		logic             lock;
		logic             blend;
		logic [POS_W-1:0] pa;
		logic [POS_W-1:0] pb;
		logic [COL_W-1:0] ca;
		logic [COL_W-1:0] cb;
	} crs_tok_t;
endpackage
`default_nettype wire

### sv/crs_if.sv
// Channel interfaces of the color ramp sampler: input items and result items.
// Depends on crs_pkg.
`default_nettype none
interface crs_in_if;
	logic                            valid;
	logic                            ready;
	logic                            cmd;
	logic [crs_pkg::IDX_W-1:0]       stop_index;
	logic [crs_pkg::POS_W-1:0]       stop_position;
	logic [7:0]                      stop_red;
	logic [7:0]                      stop_green;
	logic [7:0]                      stop_blue;
	logic [7:0]                      stop_alpha;
	logic signed [crs_pkg::SAMPLE_W-1:0] sample_position;

	modport source (output valid, cmd, stop_index, stop_position, stop_red, stop_green,
		stop_blue, stop_alpha, sample_position, input ready);
	modport sink (input valid, cmd, stop_index, stop_position, stop_red, stop_green,
		stop_blue, stop_alpha, sample_position, output ready);
endinterface

interface crs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface
`default_nettype wire

### sv/crs_cell.sv
// One stop cell of the color ramp sampler: holds a stop and refines the search token.
// Depends on crs_pkg.
`default_nettype none
module crs_cell #(
	parameter int IDX       = 0,
	parameter int MAX_STOPS = crs_pkg::MAX_STOPS_DEF,
	parameter int NW        = $clog2(MAX_STOPS + 1)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          wr_en,
	input  wire [crs_pkg::IDX_W-1:0]     wr_index,
	input  wire [crs_pkg::POS_W-1:0]     wr_pos,
	input  wire [crs_pkg::COL_W-1:0]     wr_col,
	input  wire [NW-1:0]                 n,
	input  wire crs_pkg::crs_tok_t       tok_in,
	input  wire                          vld_in,
	input  wire [crs_pkg::POS_W-1:0]     prev_pos,
	input  wire [crs_pkg::COL_W-1:0]     prev_col,
	output crs_pkg::crs_tok_t            tok_out,
	output logic                         vld_out,
	output logic [crs_pkg::POS_W-1:0]    pos,
	output logic [crs_pkg::COL_W-1:0]    col
);
	localparam bit WRITABLE = IDX < (1 << crs_pkg::IDX_W);
	localparam logic [crs_pkg::IDX_W-1:0] IDX_L = crs_pkg::IDX_W'(IDX);
	localparam logic [NW-1:0] IDX_N = NW'(IDX);
	localparam logic [NW-1:0] IDX_N1 = NW'(IDX + 1);

	logic [crs_pkg::POS_W-1:0] pos_q;
	logic [crs_pkg::COL_W-1:0] col_q;
	crs_pkg::crs_tok_t tok_q;
	crs_pkg::crs_tok_t nxt;
	logic is_last;
	logic in_use;

	assign pos = pos_q;
	assign col = col_q;
	assign tok_out = tok_q;

	always_ff @(posedge clk) begin
		if (WRITABLE && wr_en && wr_index == IDX_L) begin
			pos_q <= wr_pos;
			col_q <= wr_col;
		end
	end

	assign is_last = (IDX_N1 == n);
	assign in_use  = (IDX_N < n);

	always_comb begin
		nxt = tok_in;
		if (!tok_in.lock && in_use) begin
			if (IDX == 0) begin
				if (is_last || tok_in.t <= pos_q) begin
					nxt.lock  = 1'b1;
					nxt.blend = 1'b0;
					nxt.ca    = col_q;
				end
			end else if (is_last && tok_in.t >= pos_q) begin
				// Past the last stop: its color wins over any segment found.
				nxt.lock  = 1'b1;
				nxt.blend = 1'b0;
				nxt.ca    = col_q;
			end else if (!tok_in.blend && tok_in.t <= pos_q) begin
				nxt.blend = 1'b1;
				nxt.pa    = prev_pos;
				nxt.ca    = prev_col;
				nxt.pb    = pos_q;
				nxt.cb    = col_q;
			end else if (is_last && !tok_in.blend) begin
				nxt.lock = 1'b1;
				nxt.ca   = col_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
	end
endmodule
`default_nettype wire

### sv/crs_blend.sv
// Segment blend unit: multiplies out the weighted sum, then divides by restoring steps.
// Depends on crs_pkg.
`default_nettype none
module crs_blend (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire crs_pkg::crs_tok_t    tok,
	output logic                      done,
	output logic [crs_pkg::COL_W-1:0] color
);
	localparam int PW = crs_pkg::POS_W;
	localparam int NUM_W = 27;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_MUL  = 3'b010,
		B_DIV  = 3'b100
	} blend_state_t;

	blend_state_t state_q;
	logic [PW-1:0] span_q, d_q;
	logic [crs_pkg::COL_W-1:0] ca_q, cb_q;
	logic [NUM_W-1:0] rem_q [4];
	logic [7:0] quo_q [4];
	logic [PW:0] den_q;
	logic [2:0] k_q;
	logic [PW-1:0] span_c, dr_c;
	logic [NUM_W-1:0] trial_c;

	assign span_c  = tok.pb - tok.pa;
	assign dr_c    = (tok.t > tok.pa) ? (tok.t - tok.pa) : '0;
	assign trial_c = NUM_W'({den_q, 7'b0} >> (3'd7 - k_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (start) begin
						if (tok.lock || tok.pb <= tok.pa) begin
							done <= 1'b1;
						end else begin
							state_q <= B_MUL;
						end
					end
				end
				B_MUL: state_q <= B_DIV;
				B_DIV: begin
					if (k_q == 3'd0) begin
						done    <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (start) begin
					color  <= tok.ca;
					span_q <= span_c;
					d_q    <= (dr_c > span_c) ? span_c : dr_c;
					ca_q   <= tok.ca;
					cb_q   <= tok.cb;
				end
			end
			B_MUL: begin
				for (int l = 0; l < 4; l++) begin
					rem_q[l] <= NUM_W'({NUM_W'(ca_q[31-8*l -: 8]) * NUM_W'(span_q - d_q)
						+ NUM_W'(cb_q[31-8*l -: 8]) * NUM_W'(d_q), 1'b0}
						+ NUM_W'(span_q));
					quo_q[l] <= '0;
				end
				den_q <= {span_q, 1'b0};
				k_q   <= 3'd7;
			end
			B_DIV: begin
				for (int l = 0; l < 4; l++) begin
					if (rem_q[l] >= trial_c) begin
						rem_q[l] <= rem_q[l] - trial_c;
						quo_q[l] <= {quo_q[l][6:0], 1'b1};
					end else begin
						quo_q[l] <= {quo_q[l][6:0], 1'b0};
					end
				end
				k_q <= k_q - 3'd1;
				if (k_q == 3'd0) begin
					color <= {quo_q[0][6:0], rem_q[0] >= trial_c,
						quo_q[1][6:0], rem_q[1] >= trial_c,
						quo_q[2][6:0], rem_q[2] >= trial_c,
						quo_q[3][6:0], rem_q[3] >= trial_c};
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### sv/color_ramp_sampler_unit.sv
// Color ramp sampler, top level: input and result channels, stop count register,
// the row of stop cells and the blend unit. Depends on crs_pkg, crs_if, crs_cell, crs_blend.
//
// The block turns a scalar sample into an RGBA color from a table of up to MAX_STOPS
// color stops. An input transfer with cmd 0 stores one stop into the cell chosen by
// stop_index and gives no result. An input transfer with cmd 1 clamps the sample to
// 0..1.0 (65536) and gives one result transfer. The sample's search token walks down
// the row of stop cells, one cell a cycle, through all MAX_STOPS cells. When the sample
// falls inside a segment, the blend unit adds setup and multiplication and then eight
// restoring division steps, one quotient bit per cycle for all four channels at once;
// otherwise the end color goes out at once. The block takes its next input transfer
// once the result has been taken. stop_count may only be written while no sample is in
// flight. Stops must be written in ascending position order, and a sample must only
// reach entries already written.
`default_nettype none
module color_ramp_sampler_unit #(
	parameter int MAX_STOPS = crs_pkg::MAX_STOPS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	crs_in_if.sink                     in_ch,
	crs_out_if.source                  out_ch,
	input  wire                        cfg_we,
	input  wire [crs_pkg::CNT_W-1:0]   cfg_wdata
);
	localparam int NW = $clog2(MAX_STOPS + 1);
	localparam int CW = (NW > crs_pkg::CNT_W) ? NW : crs_pkg::CNT_W;

	// One-hot control: waiting for an item, sample in flight, result on show.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_OUT  = 3'b100
	} top_state_t;

	top_state_t state_q;
	logic [crs_pkg::CNT_W-1:0] stop_count_q;
	logic [CW-1:0] count_ext;
	logic [NW-1:0] n_c;
	logic in_xfer, wr_en;
	logic [crs_pkg::POS_W-1:0] t_c;

	crs_pkg::crs_tok_t tok_c [MAX_STOPS+1];
	logic vld_c [MAX_STOPS+1];
	logic [crs_pkg::POS_W-1:0] pos_c [MAX_STOPS];
	logic [crs_pkg::COL_W-1:0] col_c [MAX_STOPS];

	logic blend_done;
	logic [crs_pkg::COL_W-1:0] blend_color;
	logic [crs_pkg::COL_W-1:0] out_q;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign wr_en       = in_xfer && (in_ch.cmd == crs_pkg::CMD_WRITE);

	// A stop count beyond the table size uses the whole table.
	assign count_ext = CW'(stop_count_q);
	assign n_c = (count_ext > CW'(MAX_STOPS)) ? NW'(MAX_STOPS) : NW'(count_ext);

	// Clamp the signed sample to 0..1.0.
	always_comb begin
		if (in_ch.sample_position[crs_pkg::SAMPLE_W-1]) begin
			t_c = '0;
		end else if (in_ch.sample_position[crs_pkg::POS_W-1:0] > crs_pkg::ONE_POS) begin
			t_c = crs_pkg::ONE_POS;
		end else begin
			t_c = in_ch.sample_position[crs_pkg::POS_W-1:0];
		end
	end

	// The token enters the first cell; with no stops in use it is settled as black.
	always_comb begin
		tok_c[0]       = '0;
		tok_c[0].t     = t_c;
		tok_c[0].lock  = (n_c == '0);
		vld_c[0]       = in_xfer && (in_ch.cmd == crs_pkg::CMD_SAMPLE);
	end

	for (genvar i = 0; i < MAX_STOPS; i++) begin : g_cell
		logic [crs_pkg::POS_W-1:0] prev_pos;
		logic [crs_pkg::COL_W-1:0] prev_col;
		if (i == 0) begin : g_first
			assign prev_pos = '0;
			assign prev_col = '0;
		end else begin : g_rest
			assign prev_pos = pos_c[i-1];
			assign prev_col = col_c[i-1];
		end
		crs_cell #(.IDX(i), .MAX_STOPS(MAX_STOPS), .NW(NW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en),
			.wr_index (in_ch.stop_index),
			.wr_pos   (in_ch.stop_position),
			.wr_col   ({in_ch.stop_red, in_ch.stop_green, in_ch.stop_blue,
				in_ch.stop_alpha}),
			.n        (n_c),
			.tok_in   (tok_c[i]),
			.vld_in   (vld_c[i]),
			.prev_pos (prev_pos),
			.prev_col (prev_col),
			.tok_out  (tok_c[i+1]),
			.vld_out  (vld_c[i+1]),
			.pos      (pos_c[i]),
			.col      (col_c[i])
		);
	end

	crs_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vld_c[MAX_STOPS]),
		.tok    (tok_c[MAX_STOPS]),
		.done   (blend_done),
		.color  (blend_color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			stop_count_q <= '0;
		end else begin
			if (cfg_we) begin
				stop_count_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (vld_c[0]) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (blend_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The result register holds the color for the whole time it is on show.
	always_ff @(posedge clk) begin
		if (blend_done) begin
			out_q <= blend_color;
		end
	end

	assign out_ch.valid     = (state_q == S_OUT);
	assign out_ch.out_red   = out_q[31:24];
	assign out_ch.out_green = out_q[23:16];
	assign out_ch.out_blue  = out_q[15:8];
	assign out_ch.out_alpha = out_q[7:0];
endmodule
`default_nettype wire

### sv/crs_checker.sv
// Port-level checker of the color ramp sampler and its bind to the top level.
// Depends on color_ramp_sampler_unit_macros.svh and color_ramp_sampler_unit.
`default_nettype none
`include "color_ramp_sampler_unit_macros.svh"
module crs_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire [31:0] out_color
);
	// A shown result stays until it is taken.
	`CRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_color))
	// No input is taken while a result waits.
	`CRS_ASSERT_NOW(a_no_accept_with_result, clk, arst_n, out_valid, !in_ready)
	// A result never shows in the cycle after an input transfer.
	`CRS_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && in_ready, !out_valid)
	// Each result is given once.
	`CRS_ASSERT_NEXT(a_single_result, clk, arst_n, out_valid && out_ready, !out_valid)
endmodule

bind color_ramp_sampler_unit crs_checker u_crs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_color ({out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.out_alpha})
);
`default_nettype wire

### tb/color_ramp_sampler_unit_tb.sv
// Testbench of the color ramp sampler: drives stop writes and samples, predicts each color.
// Depends on crs_pkg, crs_if and color_ramp_sampler_unit.
`default_nettype none
module color_ramp_sampler_unit_tb;
	localparam int NSTOP = crs_pkg::MAX_STOPS_DEF;

	// One input transfer as the driver holds it.
	typedef struct {
		logic                                cmd;
		logic [crs_pkg::IDX_W-1:0]           idx;
		logic [crs_pkg::POS_W-1:0]           pos;
		logic [7:0]                          red;
		logic [7:0]                          green;
		logic [7:0]                          blue;
		logic [7:0]                          alpha;
		logic signed [crs_pkg::SAMPLE_W-1:0] sample;
	} ramp_item_t;

	// One RGBA color, as the result channel carries it.
	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [crs_pkg::CNT_W-1:0] cfg_wdata;

	crs_in_if  in_ch();
	crs_out_if out_ch();

	color_ramp_sampler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Our own copy of the block's state: the stop table and the stop count.
	logic [crs_pkg::POS_W-1:0] stop_pos_tbl [NSTOP];
	rgba_t                     stop_rgba_tbl [NSTOP];
	int unsigned               stops_in_use;

	ramp_item_t pending_items[$];
	rgba_t      expected_colors[$];
	ramp_item_t held_item;
	int unsigned errors;
	int unsigned cycle_no;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Both sides stall with a chance of 22 in a hundred, except in one long calm stretch
	// where the channels run back to back.
	function automatic bit stall_now();
		if (cycle_no >= 8000 && cycle_no < 12000)
			return 1'b0;
		return $urandom_range(0, 99) < 22;
	endfunction

	// Blend one channel between stop colors ca and cb; rounds half up.
	function automatic logic [7:0] mix_channel(logic [7:0] ca, logic [7:0] cb,
			longint unsigned span, longint unsigned d);
		longint unsigned num;
		num = ca * (span - d) + cb * d;
		return 8'((2 * num + span) / (2 * span));
	endfunction

	// The color of the ramp at one sample position.
	function automatic rgba_t ramp_color(logic signed [crs_pkg::SAMPLE_W-1:0] sample);
		longint unsigned t, pa, pb, span, d;
		int unsigned n;
		rgba_t ca, cb, res;
		res = '{8'd0, 8'd0, 8'd0, 8'd0};
		// Negative samples clamp to 0 and samples past 1.0 clamp to 1.0.
		if (sample < 0)
			t = 0;
		else if (sample > $signed({1'b0, crs_pkg::ONE_POS}))
			t = crs_pkg::ONE_POS;
		else
			t = longint'(sample);
		// A stop count above the table size counts as the whole table.
		n = (stops_in_use > NSTOP) ? NSTOP : stops_in_use;
		if (n == 0)
			return res;
		if (n == 1 || t <= stop_pos_tbl[0])
			return stop_rgba_tbl[0];
		if (t >= stop_pos_tbl[n-1])
			return stop_rgba_tbl[n-1];
		for (int i = 1; i < n; i++) begin
			if (t <= stop_pos_tbl[i]) begin
				pa = stop_pos_tbl[i-1];
				pb = stop_pos_tbl[i];
				ca = stop_rgba_tbl[i-1];
				cb = stop_rgba_tbl[i];
				// An empty or reversed segment gives the lower stop's color.
				if (pb <= pa)
					return ca;
				span = pb - pa;
				d = (t > pa) ? t - pa : 0;
				if (d > span)
					d = span;
				res.red   = mix_channel(ca.red, cb.red, span, d);
				res.green = mix_channel(ca.green, cb.green, span, d);
				res.blue  = mix_channel(ca.blue, cb.blue, span, d);
				res.alpha = mix_channel(ca.alpha, cb.alpha, span, d);
				return res;
			end
		end
		return stop_rgba_tbl[n-1];
	endfunction

	// Bring the predictor up to date with one accepted transfer.
	function automatic void absorb_item(ramp_item_t it);
		if (it.cmd == crs_pkg::CMD_WRITE) begin
			stop_pos_tbl[it.idx] = it.pos;
			stop_rgba_tbl[it.idx] = '{it.red, it.green, it.blue, it.alpha};
		end else begin
			expected_colors.insert(expected_colors.size(), ramp_color(it.sample));
		end
	endfunction

	// Input driver. An item is predicted at the edge where its transfer happens;
	// the block works in order, so the prediction order matches the result order.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			cycle_no <= cycle_no + 1;
			if (in_ch.valid && in_ch.ready)
				absorb_item(held_item);
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() > 0 && !stall_now()) begin
					held_item = pending_items.pop_front();
					in_ch.valid           <= 1'b1;
					in_ch.cmd             <= held_item.cmd;
					in_ch.stop_index      <= held_item.idx;
					in_ch.stop_position   <= held_item.pos;
					in_ch.stop_red        <= held_item.red;
					in_ch.stop_green      <= held_item.green;
					in_ch.stop_blue       <= held_item.blue;
					in_ch.stop_alpha      <= held_item.alpha;
					in_ch.sample_position <= held_item.sample;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every result transfer is checked against the oldest expected color.
	always @(posedge clk) begin
		rgba_t want;
		if (arst_n) begin
			out_ch.ready <= !stall_now();
			if (out_ch.valid && out_ch.ready) begin
				if (expected_colors.size() == 0) begin
					$display("%0t: result with none expected: r=%0d g=%0d b=%0d a=%0d", $time,
						out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.out_alpha);
					errors <= errors + 1;
				end else begin
					want = expected_colors.pop_front();
					if (out_ch.out_red !== want.red || out_ch.out_green !== want.green ||
							out_ch.out_blue !== want.blue || out_ch.out_alpha !== want.alpha) begin
						$display("%0t: mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
							$time, want.red, want.green, want.blue, want.alpha,
							out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.out_alpha);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	function automatic void queue_stop(int idx, int pos, int r, int g, int b, int a);
		ramp_item_t it;
		it = '{crs_pkg::CMD_WRITE, crs_pkg::IDX_W'(idx), crs_pkg::POS_W'(pos), 8'(r), 8'(g),
			8'(b), 8'(a), crs_pkg::SAMPLE_W'($urandom)};
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void queue_sample(int s);
		ramp_item_t it;
		it = '{crs_pkg::CMD_SAMPLE, crs_pkg::IDX_W'($urandom), crs_pkg::POS_W'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), crs_pkg::SAMPLE_W'(s)};
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Load all sixteen stops. Style 0 is a sorted ramp, style 1 a sorted ramp with many
	// repeated positions (empty segments), style 2 an unsorted ramp.
	function automatic void queue_ramp(int style);
		int p[$];
		for (int i = 0; i < NSTOP; i++) begin
			if (style == 1)
				p.insert(p.size(), $urandom_range(0, 4) * 16384);
			else
				p.insert(p.size(), $urandom_range(0, 65536));
		end
		if (style != 2)
			p.sort();
		for (int i = 0; i < NSTOP; i++)
			queue_stop(i, p[i], $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));
	endfunction

	// Random sample: mostly inside 0..1.0, some over the whole signed field.
	function automatic int pick_sample();
		if ($urandom_range(0, 99) < 70)
			return $urandom_range(0, 65536);
		return $urandom_range(0, 262143) - 131072;
	endfunction

	// Wait until the block has nothing in flight, then let a write item drain as well.
	// The check runs at the falling edge, when the driver's updates have all settled.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() > 0 || in_ch.valid || expected_colors.size() > 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_stop_count(int n);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= crs_pkg::CNT_W'(n);
		stops_in_use = n;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int counts[$];
		in_ch.valid = 1'b0;
		in_ch.cmd = crs_pkg::CMD_WRITE;
		in_ch.stop_index = '0;
		in_ch.stop_position = '0;
		in_ch.stop_red = '0;
		in_ch.stop_green = '0;
		in_ch.stop_blue = '0;
		in_ch.stop_alpha = '0;
		in_ch.sample_position = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		cycle_no = 0;
		stops_in_use = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. With no stops in use every sample is black, even the extremes.
		queue_sample(-131072);
		queue_sample(131071);
		queue_sample(0);
		// A ramp from position 0 to 1.0, then stops 9 and 10 rewritten as a reversed pair.
		for (int i = 0; i < NSTOP; i++)
			queue_stop(i, (i == 0) ? 0 : (i == 15) ? 65536 : (i == 7) ? 28672 : i * 4096,
				(i == 15) ? 255 : i * 16, 255 - i * 16, (i == 8) ? 0 : 255, i * 17);
		queue_stop(9, 30000, 0, 0, 0, 0);
		queue_stop(10, 20000, 255, 255, 255, 255);
		wait_idle();
		set_stop_count(16);
		queue_sample(-131072);
		queue_sample(-1);
		queue_sample(0);
		queue_sample(2048);
		queue_sample(4096);
		queue_sample(28672);
		queue_sample(25000);
		queue_sample(65535);
		queue_sample(65536);
		queue_sample(65537);
		queue_sample(131071);

		// Random phases through many stop counts, the extremes and the excess values among them.
		counts = '{1, 2, 16, 31, 0, 3, 17, 8, 16, 15, 2, 16, 5, 31, 12};
		foreach (counts[k]) begin
			wait_idle();
			set_stop_count(counts[k]);
			queue_ramp((k % 5 == 3) ? 2 : (k % 5 == 1) ? 1 : 0);
			for (int j = 0; j < 95; j++) begin
				if ($urandom_range(0, 99) < 12)
					queue_stop($urandom_range(0, 15), $urandom_range(0, 65536),
						$urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
				else
					queue_sample(pick_sample());
			end
		end

		wait_idle();
		if (errors == 0)
			$display("color_ramp_sampler_unit_tb: PASS");
		else
			$display("color_ramp_sampler_unit_tb: FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("color_ramp_sampler_unit_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
